/* hw/rtl/one_shot_timer_slot_table_macros.svh */
// Assertion macros for the one-shot timer slot table.
// Used by the sequencer; SYNTH selects empty bodies for synthesis.
`ifndef ONE_SHOT_TIMER_SLOT_TABLE_MACROS_SVH
`define ONE_SHOT_TIMER_SLOT_TABLE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define OTST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("otst: assertion failed");
// next-cycle implication
`define OTST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("otst: assertion failed");
`else
`define OTST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OTST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/otst_pkg.sv */
// Package for the one-shot timer slot table: sizes, codes and item types.
// No dependencies.
package otst_pkg;

	localparam int SLOTS = 8;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

	typedef enum logic [1:0] {
		FN_SCHEDULE = 2'd0,
		FN_CANCEL   = 2'd1,
		FN_TICK     = 2'd2,
		FN_POLL     = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		RK_SCHEDULED = 2'd0,
		RK_FULL      = 2'd1,
		RK_CANCELED  = 2'd2,
		RK_FIRED     = 2'd3
	} result_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		func_t       func;
		logic [7:0]  task_id;
		logic [31:0] delay_ticks;
	} cmd_t;

	typedef struct packed {
		result_kind_t result_kind;
		logic [2:0]   slot_index;
		logic [7:0]   fired_task;
		logic [3:0]   removed_count;
		logic         last_result;
	} result_t;

	// one slot as read at the scan index
	typedef struct packed {
		logic        busy;
		logic [7:0]  task_id;
		logic [31:0] remaining;
	} slot_rd_t;

	// write request into the slot store
	typedef struct packed {
		logic             set_busy;
		logic             clr_busy;
		logic             wr_entry;
		logic             wr_rem;
		logic [IDX_W-1:0] idx;
		logic [7:0]       task_id;
		logic [31:0]      remaining;
	} slot_wr_t;

	// shared unit results
	typedef struct packed {
		logic        id_match;
		logic        rem_zero;
		logic [31:0] rem_dec;
	} alu_out_t;

endpackage

/* hw/rtl/otst_slot_store.sv */
// Slot store: busy bits (reset), task ids and tick counts (no reset).
// Depends on otst_pkg.
module otst_slot_store
	import otst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	input  slot_wr_t         wr,
	output slot_rd_t         rd
);

	logic [SLOTS-1:0] busy_q;
	logic [7:0]       task_q [SLOTS];
	logic [31:0]      rem_q  [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else if (wr.set_busy) begin
			busy_q[wr.idx] <= 1'b1;
		end else if (wr.clr_busy) begin
			busy_q[wr.idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.wr_entry) begin
			task_q[wr.idx] <= wr.task_id;
		end
		if (wr.wr_entry || wr.wr_rem) begin
			rem_q[wr.idx] <= wr.remaining;
		end
	end

	assign rd.busy      = busy_q[rd_idx];
	assign rd.task_id   = task_q[rd_idx];
	assign rd.remaining = rem_q[rd_idx];

endmodule

/* hw/rtl/otst_alu.sv */
// Shared slot unit: id compare, zero test and decrement of one slot.
// Depends on otst_pkg.
module otst_alu
	import otst_pkg::*;
(
	input  slot_rd_t   rd,
	input  logic [7:0] task_id,
	output alu_out_t   res
);

	assign res.id_match = (rd.task_id == task_id);
	assign res.rem_zero = (rd.remaining == 32'd0);
	assign res.rem_dec  = rd.remaining - 32'd1;

endmodule

/* hw/rtl/otst_seq.sv */
// Sequencer: walks the slots one per cycle and forms the result items.
// Depends on otst_pkg and the assertion macros header.
`include "one_shot_timer_slot_table_macros.svh"
module otst_seq
	import otst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cmd_t             cmd,
	input  slot_rd_t         rd,
	input  alu_out_t         alu,
	output logic             busy,
	output logic [IDX_W-1:0] idx,
	output slot_wr_t         wr,
	output logic             emit,
	output result_t          res
);

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	cmd_t             op_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_vld_q;
	logic [IDX_W-1:0] pend_slot_q;
	logic [7:0]       pend_task_q;
	logic             accept;
	logic             at_last;
	logic             hit;
	logic             due;

	assign accept  = start && (state_q == ST_IDLE);
	assign at_last = (idx_q == LAST_SLOT);
	assign busy    = (state_q != ST_IDLE);
	assign idx     = idx_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				case (op_q.func)
					FN_SCHEDULE: if (!rd.busy || at_last) state_d = ST_IDLE;
					FN_POLL:     if (at_last) state_d = ST_FLUSH;
					default:     if (at_last) state_d = ST_IDLE;
				endcase
			end
			ST_FLUSH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		wr           = '0;
		wr.idx       = idx_q;
		wr.task_id   = op_q.task_id;
		wr.remaining = alu.rem_dec;
		emit         = 1'b0;
		res          = '0;
		hit          = rd.busy && alu.id_match;
		due          = rd.busy && alu.rem_zero;
		case (state_q)
			ST_SCAN: begin
				case (op_q.func)
					FN_SCHEDULE: begin
						res.last_result = 1'b1;
						if (!rd.busy) begin
							wr.set_busy     = 1'b1;
							wr.wr_entry     = 1'b1;
							wr.remaining    = op_q.delay_ticks;
							emit            = 1'b1;
							res.result_kind = RK_SCHEDULED;
							res.slot_index  = 3'(idx_q);
						end else if (at_last) begin
							emit            = 1'b1;
							res.result_kind = RK_FULL;
						end
					end
					FN_CANCEL: begin
						wr.clr_busy = hit;
						if (at_last) begin
							emit              = 1'b1;
							res.result_kind   = RK_CANCELED;
							res.removed_count = 4'(cnt_q + CNT_W'(hit));
							res.last_result   = 1'b1;
						end
					end
					FN_TICK: begin
						wr.wr_rem = rd.busy && !alu.rem_zero;
					end
					FN_POLL: begin
						wr.clr_busy = due;
						// a newer due slot proves the held one is not last
						if (due && pend_vld_q) begin
							emit            = 1'b1;
							res.result_kind = RK_FIRED;
							res.slot_index  = 3'(pend_slot_q);
							res.fired_task  = pend_task_q;
						end
					end
					default: ;
				endcase
			end
			ST_FLUSH: begin
				if (pend_vld_q) begin
					emit            = 1'b1;
					res.result_kind = RK_FIRED;
					res.slot_index  = 3'(pend_slot_q);
					res.fired_task  = pend_task_q;
					res.last_result = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			cnt_q      <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q      <= '0;
				cnt_q      <= '0;
				pend_vld_q <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				idx_q <= idx_q + IDX_W'(1);
				if (op_q.func == FN_CANCEL) cnt_q <= cnt_q + CNT_W'(hit);
				if (op_q.func == FN_POLL && due) pend_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= cmd;
		end
		if (state_q == ST_SCAN && op_q.func == FN_POLL && due) begin
			pend_slot_q <= idx_q;
			pend_task_q <= rd.task_id;
		end
	end

	`OTST_ASSERT_NXT(a_accept_scans, clk, arst_n, accept, state_q == ST_SCAN)
	`OTST_ASSERT_NXT(a_scan_steps, clk, arst_n, state_q == ST_SCAN && state_d == ST_SCAN, idx_q == $past(idx_q) + IDX_W'(1))
	`OTST_ASSERT_NXT(a_flush_once, clk, arst_n, state_q == ST_FLUSH, state_q == ST_IDLE)
	`OTST_ASSERT_IMP(a_emit_busy, clk, arst_n, emit, state_q != ST_IDLE)
	`OTST_ASSERT_IMP(a_cnt_range, clk, arst_n, state_q == ST_SCAN, cnt_q <= CNT_W'(SLOTS))

endmodule

/* hw/rtl/one_shot_timer_slot_table.sv */
// Top level of the one-shot timer slot table.
// Depends on otst_pkg, otst_slot_store, otst_alu and otst_seq.
//
// A table of SLOTS one-shot timer slots, each with a busy bit, a task id and
// a 32-bit remaining tick count. An item is taken when start is high while
// busy is low; func selects schedule, cancel, tick or poll. After accept the
// sequencer walks the slots in order, one slot per clock, through a single
// shared compare/decrement unit, so busy stays high for the scan: schedule
// stops at the first free slot, cancel, tick and poll walk every slot, and
// poll then passes through a flush state to release its held result.
// busy drops once the scan (and for poll the flush) is over, and start may be high again then.
// Results come out of an output register, each valid for exactly one cycle
// while done is high; the receiver cannot stall, so it must take every
// strobe. Schedule and cancel give one result (last_result set); tick gives
// none; poll gives one result per due slot in slot order, the final one with
// last_result set, or none if nothing is due. A poll result is sent once the
// scan finds the next due slot, or in the flush, so poll results may come
// with gaps between them. Unused result fields read zero. Busy bits
// clear at reset; ids and counts hold garbage until a schedule writes them.
module one_shot_timer_slot_table
	import otst_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	logic [IDX_W-1:0] idx;
	slot_wr_t         wr;
	slot_rd_t         rd;
	alu_out_t         alu;
	logic             emit;
	result_t          res;
	logic             done_q;
	result_t          result_q;

	// slot storage, read at the scan index
	otst_slot_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (idx),
		.wr     (wr),
		.rd     (rd)
	);

	// the one compare/decrement unit shared by every step of the scan;
	// the id under compare is the one the store write carries (latched item)
	otst_alu u_alu (
		.rd      (rd),
		.task_id (wr.task_id),
		.res     (alu)
	);

	// scan sequencer and result formation
	otst_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.rd     (rd),
		.alu    (alu),
		.busy   (busy),
		.idx    (idx),
		.wr     (wr),
		.emit   (emit),
		.res    (res)
	);

	// output register: one-cycle strobe per result item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
